// ----- rtl/fatc_pkg.sv -----
// Package with shared constants, types and character maps for the FAT file name checker.
`timescale 1ns / 1ps

package fatc_pkg;

    localparam int MAX_NAME_CHARS = 255;

    localparam int UNIT_W = 16;
    localparam int KEPT_W = 9;
    localparam int CNT_W  = $clog2(MAX_NAME_CHARS + 2);
    localparam int BASE_W = 4;
    localparam int EXT_W  = 3;

    localparam logic [BASE_W-1:0] BASE_SAT = BASE_W'(9);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(8);
    localparam logic [EXT_W-1:0]  EXT_SAT  = EXT_W'(4);
    localparam logic [EXT_W-1:0]  EXT_MAX  = EXT_W'(3);

    localparam logic [CNT_W-1:0]  COUNT_SAT = CNT_W'(MAX_NAME_CHARS + 1);
    localparam logic [CNT_W-1:0]  COUNT_MAX = CNT_W'(MAX_NAME_CHARS);
    localparam logic [CNT_W:0]    KEPT_SAT  = (CNT_W + 1)'((1 << KEPT_W) - 1);

    localparam logic [UNIT_W-1:0] CHAR_PERIOD  = 16'h002E;
    localparam logic [UNIT_W-1:0] CHAR_SPACE   = 16'h0020;
    localparam logic [UNIT_W-1:0] CHAR_LOWER_A = 16'h0061;
    localparam logic [UNIT_W-1:0] CHAR_LOWER_Z = 16'h007A;
    localparam logic [UNIT_W-1:0] CASE_OFFSET  = 16'h0020;
    localparam logic [UNIT_W-1:0] ASCII_LIMIT  = 16'h0080;
    localparam logic [UNIT_W-1:0] BYTE_LIMIT   = 16'h0100;

    localparam logic [127:0] SHORT_MAP = {32'h6FFFFFFF, 32'hC7FFFFFF, 32'h03FF63FA, 32'h00000000};
    localparam logic [127:0] LONG_MAP  = {32'h6FFFFFFF, 32'hEFFFFFFF, 32'h2BFF7BFA, 32'h00000000};

    typedef struct packed {
        logic              error_seen;
        logic              period_seen;
        logic [BASE_W-1:0] base_count;
        logic [EXT_W-1:0]  ext_count;
        logic [CNT_W-1:0]  unit_count;
        logic [CNT_W-1:0]  tail_position;
    } name_state_t;

    typedef struct packed {
        logic [UNIT_W-1:0] mapped_unit;
        logic              name_done;
        logic              name_valid;
        logic [KEPT_W-1:0] kept_length;
    } name_result_t;

endpackage

// ----- rtl/fat_filename_checker.sv -----
// Top level of the FAT file name checker with input, state and result registers.
`timescale 1ns / 1ps

// The block checks a file name that arrives as one UTF-16 code unit per
// transaction on the s_ channel, with s_final_unit marking the last unit.
// Every input transaction yields exactly one result transaction on the m_
// channel carrying the mapped unit; the result of the last unit also carries
// the verdict and the kept length of the name.
// The mode register is written through the cfg_ channel, which is always
// ready, and must only be written while no name is in flight.
// A code unit is held in an input register, evaluated against the per name
// state, and the result is stored in an output register. One code unit per
// cycle is sustained while the receiver does not stall, since the state
// update is a single short step.
// When the receiver stalls, the output register holds its result and the
// input register takes one more unit before s_ready falls.
// Reset clears the mode to long-name rules, empties both registers and
// clears the per name state.
module fat_filename_checker
    import fatc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [UNIT_W-1:0] s_code_unit,
    input  logic              s_final_unit,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [UNIT_W-1:0] m_mapped_unit,
    output logic              m_name_done,
    output logic              m_name_valid,
    output logic [KEPT_W-1:0] m_kept_length
);

    logic              mode_reg;
    logic              in_valid_reg;
    logic [UNIT_W-1:0] unit_reg;
    logic              final_reg;
    logic              out_valid_reg;
    name_result_t      result_reg;
    name_state_t       state_reg;
    name_state_t       state_next;
    name_result_t      result_next;
    logic              advance;

    assign cfg_ready = 1'b1;
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    fatc_eval u_eval (
        .code_unit       (unit_reg),
        .final_unit      (final_reg),
        .short_name_mode (mode_reg),
        .state_cur       (state_reg),
        .state_next      (state_next),
        .result          (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            unit_reg <= s_code_unit;
            final_reg <= s_final_unit;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_mapped_unit = result_reg.mapped_unit;
    assign m_name_done = result_reg.name_done;
    assign m_name_valid = result_reg.name_valid;
    assign m_kept_length = result_reg.kept_length;

`ifndef SYNTHESIS
    a_valid_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_name_valid |-> m_name_done)
        else $error("name_valid set on a result that does not end a name");

    a_kept_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kept_length != '0) |-> m_name_valid)
        else $error("kept_length nonzero on a result without a valid name");

    a_clear_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && final_reg |=> (state_reg == name_state_t'('0)))
        else $error("name state not cleared after the last code unit");

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled while the pipeline could move");
`endif

endmodule

// ----- rtl/fatc_eval.sv -----
// Per code unit evaluation: character checks, counter updates and the final verdict.
`timescale 1ns / 1ps

module fatc_eval
    import fatc_pkg::*;
(
    input  logic [UNIT_W-1:0] code_unit,
    input  logic              final_unit,
    input  logic              short_name_mode,
    input  name_state_t       state_cur,
    output name_state_t       state_next,
    output name_result_t      result
);

    name_state_t       upd;
    logic              is_period;
    logic              is_trim;
    logic              short_bad;
    logic              long_bad;
    logic              ok;
    logic [CNT_W:0]    kept_wide;
    logic [UNIT_W-1:0] mapped;

    always_comb begin
        upd = state_cur;
        is_period = (code_unit == CHAR_PERIOD);
        is_trim = is_period || (code_unit == CHAR_SPACE);
        short_bad = (code_unit >= ASCII_LIMIT) || !SHORT_MAP[code_unit[6:0]];
        long_bad = (code_unit < BYTE_LIMIT)
                   && ((code_unit >= ASCII_LIMIT) || !LONG_MAP[code_unit[6:0]]);
        mapped = code_unit;

        if (state_cur.unit_count < COUNT_SAT) begin
            upd.unit_count = state_cur.unit_count + CNT_W'(1);
        end
        if (!is_trim) begin
            upd.tail_position = upd.unit_count;
        end

        if (short_name_mode) begin
            if ((code_unit >= CHAR_LOWER_A) && (code_unit <= CHAR_LOWER_Z)) begin
                mapped = code_unit - CASE_OFFSET;
            end
            if (!state_cur.error_seen) begin
                if (short_bad) begin
                    upd.error_seen = 1'b1;
                end else if (is_period) begin
                    if (state_cur.period_seen) begin
                        upd.error_seen = 1'b1;
                    end else begin
                        upd.period_seen = 1'b1;
                    end
                end else if (!state_cur.period_seen) begin
                    if (state_cur.base_count < BASE_SAT) begin
                        upd.base_count = state_cur.base_count + BASE_W'(1);
                    end
                end else begin
                    if (state_cur.ext_count < EXT_SAT) begin
                        upd.ext_count = state_cur.ext_count + EXT_W'(1);
                    end
                end
            end
        end else if (long_bad) begin
            upd.error_seen = 1'b1;
        end

        ok = !upd.error_seen && (upd.unit_count <= COUNT_MAX);
        if (short_name_mode) begin
            ok = ok && (upd.base_count != '0) && (upd.base_count <= BASE_MAX)
                 && (upd.ext_count <= EXT_MAX);
            kept_wide = {1'b0, upd.unit_count}
                        - (CNT_W + 1)'(upd.period_seen && (upd.ext_count == '0));
        end else begin
            ok = ok && (upd.tail_position != '0);
            kept_wide = {1'b0, upd.tail_position};
        end
        if (kept_wide > KEPT_SAT) begin
            kept_wide = KEPT_SAT;
        end

        result.mapped_unit = mapped;
        result.name_done = final_unit;
        result.name_valid = final_unit && ok;
        result.kept_length = (final_unit && ok) ? KEPT_W'(kept_wide) : '0;

        state_next = final_unit ? name_state_t'('0) : upd;
    end

endmodule
